// ===== hdl/pms_pkg.sv =====
// Package for the powered measurement sequencer: phase and event codes,
// request codes, register indexes, the result word type and the averaging math.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package pms_pkg;

  // Number of samples that make up one average (1 to 256).
  localparam int SAMPLES_PER_AVERAGE = 16;

  // Field and state widths.
  localparam int REQ_W     = 3;
  localparam int SAMPLE_W  = 16;
  localparam int TIME_W    = 16;
  localparam int SUM_W     = 24;
  localparam int AVG_W     = 16;
  localparam int CNT_W     = $clog2(SAMPLES_PER_AVERAGE + 1);
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;

  localparam logic [CNT_W-1:0] SPA_CNT = CNT_W'(SAMPLES_PER_AVERAGE);

  // Division of the sum by the sample count as a multiply by a rounded-up
  // reciprocal. With l = ceil(log2(count)) and a shift of SUM_W + l the
  // quotient is exact for every sum below 2**SUM_W.
  localparam int    AVG_L     = $clog2(SAMPLES_PER_AVERAGE);
  localparam int    AVG_SHIFT = SUM_W + AVG_L;
  localparam int    MULT_W    = SUM_W + 1;
  localparam longint AVG_MULT =
    ((64'd1 << AVG_SHIFT) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE;
  localparam logic [MULT_W-1:0] AVG_MULT_V = MULT_W'(AVG_MULT);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_TIME    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TIME = CFG_IDX_W'(1);

  // Request codes of the input word.
  localparam logic [REQ_W-1:0] REQ_TICK   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_SAMPLE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_STEP   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

  typedef enum logic [1:0] {
    PH_OFF     = 2'd0,
    PH_SETTLE  = 2'd1,
    PH_MEASURE = 2'd2,
    PH_HELD    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_POWER   = 2'd1,
    EV_CONVERT = 2'd2,
    EV_READY   = 2'd3
  } event_t;

  // One configuration write as seen by the core.
  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
  } cfg_write_t;

  // One result word.
  typedef struct packed {
    event_t              event_code;
    logic [AVG_W-1:0]    reading;
    logic                reading_valid;
    logic                power_on;
    logic                start_conversion;
    phase_t              phase;
    logic [TIME_W-1:0]   elapsed;
  } result_t;

  // Truncated average of a sum over SAMPLES_PER_AVERAGE samples.
  function automatic logic [AVG_W-1:0] avg_of(input logic [SUM_W-1:0] sum);
    logic [SUM_W+MULT_W-1:0] prod;
    prod = {{MULT_W{1'b0}}, sum} * {{SUM_W{1'b0}}, AVG_MULT_V};
    return prod[AVG_SHIFT +: AVG_W];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pms_ifs.sv =====
// Handshake channel interfaces of the powered measurement sequencer:
// input request words, result words and configuration writes.
// Depends on pms_pkg for the field widths.
`default_nettype none

interface pms_in_if
  import pms_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output req_type, output sample, input ready);
  modport sink   (input valid, input req_type, input sample, output ready);
endinterface

interface pms_out_if
  import pms_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [1:0]        event_code;
  logic [AVG_W-1:0]  reading;
  logic              reading_valid;
  logic              power_on;
  logic              start_conversion;
  logic [1:0]        phase;
  logic [TIME_W-1:0] elapsed;

  modport source (output valid, output event_code, output reading, output reading_valid,
                  output power_on, output start_conversion, output phase,
                  output elapsed, input ready);
  modport sink   (input valid, input event_code, input reading, input reading_valid,
                  input power_on, input start_conversion, input phase,
                  input elapsed, output ready);
endinterface

interface pms_cfg_if
  import pms_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/pms_core.sv =====
// Sequencer core: configuration registers, phase and measurement state and
// the single-pass next-state logic that forms one result word per request.
// Depends on pms_pkg.
`default_nettype none

module pms_core
  import pms_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic [REQ_W-1:0]    req_type,
  input  wire logic [SAMPLE_W-1:0] sample,
  input  wire cfg_write_t          cfg,
  output result_t                  result
);

  logic [TIME_W-1:0] off_time_r, settle_time_r;
  phase_t            phase_r, phase_nxt;
  logic [TIME_W-1:0] tick_r, tick_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [AVG_W-1:0]  avg_r, avg_nxt;
  logic              avg_valid_r, avg_valid_nxt;
  logic              power_r, power_nxt;

  // Next state and result word for the request at the input.
  always_comb begin
    logic [SUM_W-1:0] sum_base;
    event_t           ev;
    logic [AVG_W-1:0] rd;
    logic             rd_ok;
    logic             conv;
    sum_base      = '0;
    phase_nxt     = phase_r;
    tick_nxt      = tick_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    avg_nxt       = avg_r;
    avg_valid_nxt = avg_valid_r;
    power_nxt     = power_r;
    ev            = EV_NONE;
    rd            = '0;
    rd_ok         = 1'b0;
    conv          = 1'b0;
    case (req_type)
      REQ_TICK: begin
        if (tick_r != {TIME_W{1'b1}}) begin
          tick_nxt = tick_r + TIME_W'(1);
        end
      end
      REQ_SAMPLE: begin
        // A fresh measurement restarts the sum with its first sample.
        sum_base = (cnt_r == '0) ? '0 : sum_r;
        sum_nxt  = sum_base;
        if (cnt_r < SPA_CNT) begin
          sum_nxt = sum_base + {{(SUM_W-SAMPLE_W){1'b0}}, sample};
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (cnt_nxt >= SPA_CNT) begin
          avg_nxt       = avg_of(sum_nxt);
          avg_valid_nxt = 1'b1;
        end else begin
          conv = 1'b1;
        end
      end
      REQ_STEP: begin
        case (phase_r)
          PH_OFF: begin
            if (tick_r >= off_time_r) begin
              tick_nxt  = '0;
              phase_nxt = PH_SETTLE;
              power_nxt = 1'b1;
              ev        = EV_POWER;
            end
          end
          PH_SETTLE: begin
            if (tick_r >= settle_time_r) begin
              tick_nxt  = '0;
              phase_nxt = PH_MEASURE;
              conv      = 1'b1;
              ev        = EV_CONVERT;
            end
          end
          PH_MEASURE: begin
            if (avg_valid_r) begin
              phase_nxt = PH_HELD;
              ev        = EV_READY;
            end
          end
          PH_HELD: begin
            // The result phase is left only once the average has been read.
            if (!avg_valid_r) begin
              phase_nxt = PH_OFF;
              power_nxt = 1'b0;
              tick_nxt  = '0;
              ev        = EV_READY;
            end else begin
              ev = EV_POWER;
            end
          end
          default: begin
            ev = EV_NONE;
          end
        endcase
      end
      REQ_READ: begin
        // A read in the result phase hands out the average and restarts.
        if (phase_r == PH_HELD) begin
          rd            = avg_r;
          rd_ok         = 1'b1;
          avg_valid_nxt = 1'b0;
          cnt_nxt       = '0;
          phase_nxt     = PH_OFF;
          power_nxt     = 1'b0;
          tick_nxt      = '0;
        end
      end
      REQ_CLEAR: begin
        tick_nxt = '0;
      end
      default: begin
        ev = EV_NONE;
      end
    endcase
    result.event_code       = ev;
    result.reading          = rd;
    result.reading_valid    = rd_ok;
    result.power_on         = power_nxt;
    result.start_conversion = conv;
    result.phase            = phase_nxt;
    result.elapsed          = tick_nxt;
  end

  // State registers, updated on each accepted word and on configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_time_r    <= TIME_W'(1000);
      settle_time_r <= TIME_W'(10);
      phase_r       <= PH_OFF;
      tick_r        <= '0;
      sum_r         <= '0;
      cnt_r         <= '0;
      avg_r         <= '0;
      avg_valid_r   <= 1'b0;
      power_r       <= 1'b0;
    end else begin
      if (cfg.we && cfg.index == CFG_OFF_TIME) begin
        off_time_r <= cfg.data;
      end
      if (cfg.we && cfg.index == CFG_SETTLE_TIME) begin
        settle_time_r <= cfg.data;
      end
      if (accept) begin
        phase_r     <= phase_nxt;
        tick_r      <= tick_nxt;
        sum_r       <= sum_nxt;
        cnt_r       <= cnt_nxt;
        avg_r       <= avg_nxt;
        avg_valid_r <= avg_valid_nxt;
        power_r     <= power_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pms_out_stage.sv =====
// Result register of the sequencer: holds one result word until the sink
// takes it and accepts a new one in the same cycle. Depends on pms_pkg.
`default_nettype none

module pms_out_stage
  import pms_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire result_t in_word,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_word
);

  logic    valid_r;
  result_t word_r;

  // Space exists when the register is empty or is being emptied now.
  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_word  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_word;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/powered_measurement_sequencer.sv =====
// Powered measurement sequencer, top level.
// Output: a result word is registered and appears in the cycle after its request word is accepted.
// Throughput: one word per cycle while the sink keeps ready high; the single result register sets this figure.
// Reset: synchronous, active low; clears phase, counters, sum and average,
// switches power off and loads off_time 1000 and settle_time 10.
`default_nettype none

module powered_measurement_sequencer
  import pms_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  pms_in_if.sink    in_ch,
  pms_out_if.source out_ch,
  pms_cfg_if.sink   cfg_ch
);

  logic       accept;
  logic       stage_ready;
  cfg_write_t cfg;
  result_t    core_word;
  result_t    out_word;

  // Configuration writes are always taken.
  assign cfg_ch.ready = 1'b1;
  assign cfg.we       = cfg_ch.valid;
  assign cfg.index    = cfg_ch.index;
  assign cfg.data     = cfg_ch.data;

  assign in_ch.ready = stage_ready;
  assign accept      = in_ch.valid && stage_ready;

  pms_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .req_type (in_ch.req_type),
    .sample   (in_ch.sample),
    .cfg      (cfg),
    .result   (core_word)
  );

  pms_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (stage_ready),
    .in_word   (core_word),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_word  (out_word)
  );

  // Unpack the result word onto the channel.
  assign out_ch.event_code       = out_word.event_code;
  assign out_ch.reading          = out_word.reading;
  assign out_ch.reading_valid    = out_word.reading_valid;
  assign out_ch.power_on         = out_word.power_on;
  assign out_ch.start_conversion = out_word.start_conversion;
  assign out_ch.phase            = out_word.phase;
  assign out_ch.elapsed          = out_word.elapsed;

`ifndef SYNTHESIS
  // Sensor power is on exactly outside the off wait.
  a_power_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.power_on == (out_ch.phase != PH_OFF)))
    else $error("power level disagrees with phase");

  // A valid read always restarts the sequence with power off.
  a_read_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.reading_valid) |->
      (out_ch.phase == PH_OFF && !out_ch.power_on && out_ch.elapsed == '0))
    else $error("valid read did not restart the sequence");

  // An accepted request always leaves a result word in the register.
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> out_ch.valid)
    else $error("accepted word produced no result");

  // A conversion request never comes with a ready event or a read.
  a_conv_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.start_conversion) |->
      (out_ch.event_code != EV_READY && !out_ch.reading_valid))
    else $error("conversion request with ready event or read");
`endif

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the powered measurement sequencer: directed and random words
// against an in-bench predictor, with random gaps on the sender and stalls on the receiver.
// Depends on pms_pkg, the pms_*_if channel interfaces and the powered_measurement_sequencer RTL.

module testbench
  import pms_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_ROUNDS = 4;
  localparam int WORDS_PER_ROUND = 300;

  logic clk;
  logic rst_n;

  pms_in_if  in_ch();
  pms_out_if out_ch();
  pms_cfg_if cfg_ch();

  powered_measurement_sequencer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predicted sequencer state and configuration.
  phase_t              ph_q;
  logic [TIME_W-1:0]   tick_q;
  logic [SUM_W-1:0]    sum_q;
  logic [8:0]          cnt_q;
  logic [AVG_W-1:0]    avg_q;
  logic                avg_ok_q;
  logic                pwr_q;
  logic [TIME_W-1:0]   off_time_q;
  logic [TIME_W-1:0]   settle_time_q;

  // Result words predicted but not yet seen, oldest first.
  result_t pending_results[$];
  int      mismatch_count;
  int      burst_left;
  int      cycle_count;

  // Free-running clock, 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Applies one request word to the predicted state and returns the result word it causes.
  function automatic result_t advance_sequencer(input logic [REQ_W-1:0] req,
                                                input logic [SAMPLE_W-1:0] smp);
    result_t r;
    r = '0;
    r.event_code = EV_NONE;
    case (req)
      REQ_TICK: begin
        if (tick_q != '1) tick_q = tick_q + 1'b1;
      end
      REQ_SAMPLE: begin
        // The sum restarts with the first sample of a new average.
        if (cnt_q == 0) sum_q = '0;
        if (cnt_q < SAMPLES_PER_AVERAGE) begin
          sum_q = sum_q + smp;
          cnt_q = cnt_q + 1'b1;
        end
        if (cnt_q >= SAMPLES_PER_AVERAGE) begin
          avg_q = AVG_W'(sum_q / SAMPLES_PER_AVERAGE);
          avg_ok_q = 1'b1;
        end else begin
          r.start_conversion = 1'b1;
        end
      end
      REQ_STEP: begin
        case (ph_q)
          PH_OFF: begin
            if (tick_q >= off_time_q) begin
              tick_q = '0;
              ph_q = PH_SETTLE;
              pwr_q = 1'b1;
              r.event_code = EV_POWER;
            end
          end
          PH_SETTLE: begin
            if (tick_q >= settle_time_q) begin
              tick_q = '0;
              ph_q = PH_MEASURE;
              r.start_conversion = 1'b1;
              r.event_code = EV_CONVERT;
            end
          end
          PH_MEASURE: begin
            if (avg_ok_q) begin
              ph_q = PH_HELD;
              r.event_code = EV_READY;
            end
          end
          default: begin
            // The held phase is left only once the average has been consumed.
            if (!avg_ok_q) begin
              ph_q = PH_OFF;
              pwr_q = 1'b0;
              tick_q = '0;
              r.event_code = EV_READY;
            end else begin
              r.event_code = EV_POWER;
            end
          end
        endcase
      end
      REQ_READ: begin
        if (ph_q == PH_HELD) begin
          r.reading = avg_q;
          r.reading_valid = 1'b1;
          avg_ok_q = 1'b0;
          cnt_q = '0;
          ph_q = PH_OFF;
          pwr_q = 1'b0;
          tick_q = '0;
        end
      end
      REQ_CLEAR: begin
        tick_q = '0;
      end
      default: begin
      end
    endcase
    r.power_on = pwr_q;
    r.phase = ph_q;
    r.elapsed = tick_q;
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Sends one request word, called and returning at a falling edge. The sender works in
  // bursts; between bursts valid sometimes drops for a random gap.
  task automatic send_word(input logic [REQ_W-1:0] req, input logic [SAMPLE_W-1:0] smp);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.req_type <= req;
    in_ch.sample <= smp;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(advance_sequencer(req, smp));
    @(negedge clk);
  endtask

  // Stops sending and waits until every predicted word has come out.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] reg_index,
                                input logic [CFG_DAT_W-1:0] reg_data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= reg_index;
    cfg_ch.data <= reg_data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (reg_index)
      CFG_OFF_TIME:    off_time_q = reg_data;
      CFG_SETTLE_TIME: settle_time_q = reg_data;
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Both times are rewritten only with the block idle.
  task automatic set_times(input logic [TIME_W-1:0] off_ticks,
                           input logic [TIME_W-1:0] settle_ticks);
    wait_drained();
    write_register(CFG_OFF_TIME, off_ticks);
    write_register(CFG_SETTLE_TIME, settle_ticks);
  endtask

  // With the reset times: reads and steps that find nothing to do, clear, unused codes.
  task automatic check_idle_requests();
    send_word(REQ_READ, 16'hFFFF);
    send_word(REQ_STEP, 16'h0000);
    repeat (3) send_word(REQ_TICK, pick_sample());
    send_word(REQ_STEP, pick_sample());
    send_word(REQ_CLEAR, 16'hA5A5);
    send_word(3'd5, 16'h5A5A);
    send_word(3'd6, 16'hFFFF);
    send_word(3'd7, 16'h0000);
    send_word(REQ_TICK, pick_sample());
  endtask

  // Largest off and settle times hold every step back; lowering each time to the current
  // tick count then lets the step through on the equal boundary. Full-scale samples give
  // the largest average.
  task automatic check_extreme_times();
    set_times('1, '1);
    send_word(REQ_CLEAR, pick_sample());
    send_word(REQ_STEP, pick_sample());
    repeat (9) send_word(REQ_TICK, pick_sample());
    send_word(REQ_STEP, pick_sample());
    set_times(TIME_W'(9), '1);
    send_word(REQ_STEP, pick_sample());
    repeat (5) send_word(REQ_TICK, pick_sample());
    send_word(REQ_STEP, pick_sample());
    set_times(TIME_W'(9), TIME_W'(5));
    send_word(REQ_STEP, pick_sample());
    repeat (SAMPLES_PER_AVERAGE) send_word(REQ_SAMPLE, 16'hFFFF);
    send_word(REQ_STEP, pick_sample());
    // A sample past the target is dropped but the average is recomputed.
    send_word(REQ_SAMPLE, 16'h0000);
    send_word(REQ_STEP, pick_sample());
    send_word(REQ_READ, pick_sample());
    send_word(REQ_READ, pick_sample());
  endtask

  // Zero times: off and settle steps succeed at once; samples arrive in the off and settle phases too.
  task automatic check_zero_times();
    set_times('0, '0);
    send_word(REQ_SAMPLE, 16'h1234);
    send_word(REQ_STEP, pick_sample());
    send_word(REQ_SAMPLE, 16'h0000);
    send_word(REQ_READ, pick_sample());
    send_word(REQ_STEP, pick_sample());
    send_word(REQ_STEP, pick_sample());
    repeat (SAMPLES_PER_AVERAGE - 2) send_word(REQ_SAMPLE, 16'h0000);
    send_word(REQ_STEP, pick_sample());
    send_word(REQ_READ, pick_sample());
  endtask

  // Mostly well-formed measurement cycles with random samples, mixed with random words.
  task automatic check_random_sequences();
    logic [REQ_W-1:0] req;
    for (int round = 0; round < RANDOM_ROUNDS; round++) begin
      if (round == 0) begin
        set_times('0, '0);
      end else begin
        set_times(TIME_W'($urandom_range(0, 10)), TIME_W'($urandom_range(0, 10)));
      end
      repeat (WORDS_PER_ROUND) begin
        if ($urandom_range(0, 4) == 0) begin
          req = REQ_W'($urandom_range(0, 7));
        end else begin
          case (ph_q)
            PH_OFF: begin
              if (tick_q < off_time_q) begin
                req = ($urandom_range(0, 15) == 0) ? REQ_CLEAR : REQ_TICK;
              end else begin
                req = REQ_STEP;
              end
            end
            PH_SETTLE: begin
              if (tick_q < settle_time_q) begin
                req = ($urandom_range(0, 15) == 0) ? REQ_CLEAR : REQ_TICK;
              end else begin
                req = REQ_STEP;
              end
            end
            PH_MEASURE: begin
              req = avg_ok_q ? REQ_STEP : REQ_SAMPLE;
            end
            default: begin
              req = ($urandom_range(0, 3) == 0) ? REQ_STEP : REQ_READ;
            end
          endcase
        end
        send_word(req, pick_sample());
      end
    end
  endtask

  // Result receiver: ready follows a stall pattern, drawn anew from four modes whenever the current one runs out.
  initial begin : receiver
    int mode;
    int mode_left;
    int beat;
    out_ch.ready = 1'b0;
    mode = 0;
    mode_left = 0;
    beat = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 128);
      end
      mode_left--;
      beat++;
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2: out_ch.ready <= (beat % 4 != 3);
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Each accepted result word is checked against the oldest prediction.
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result word with none expected, expected nothing, actual phase %0h",
                 $time, out_ch.phase);
      end else begin
        want = pending_results.pop_front();
        compare_field("event_code", want.event_code, out_ch.event_code);
        compare_field("reading", want.reading, out_ch.reading);
        compare_field("reading_valid", want.reading_valid, out_ch.reading_valid);
        compare_field("power_on", want.power_on, out_ch.power_on);
        compare_field("start_conversion", want.start_conversion, out_ch.start_conversion);
        compare_field("phase", want.phase, out_ch.phase);
        compare_field("elapsed", want.elapsed, out_ch.elapsed);
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench failed");
    $finish;
  end

  // Reset, then the tests in turn, then the verdict.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_TICK;
    in_ch.sample = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_OFF_TIME;
    cfg_ch.data = '0;
    rst_n = 1'b0;
    mismatch_count = 0;
    burst_left = 0;
    ph_q = PH_OFF;
    tick_q = '0;
    sum_q = '0;
    cnt_q = '0;
    avg_q = '0;
    avg_ok_q = 1'b0;
    pwr_q = 1'b0;
    off_time_q = 16'd1000;
    settle_time_q = 16'd10;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    check_idle_requests();
    check_extreme_times();
    check_zero_times();
    check_random_sequences();

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/pms_pkg.sv
hdl/pms_ifs.sv
hdl/pms_core.sv
hdl/pms_out_stage.sv
hdl/powered_measurement_sequencer.sv
dv/testbench.sv
